// ===== sv/ewbs_pkg.sv =====
// Shared types and constants for the error window budget selector.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package ewbs_pkg;

    localparam int ERR_W     = 32;
    localparam int LIMIT_W   = 16;
    localparam int BASE_W    = 32;
    localparam int LEVEL_W   = 2;
    localparam int PERIOD_W  = 30;
    localparam int RUNTIME_W = 33;
    localparam int OUT_SUM_W = 36;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;
    localparam int S_DATA_W  = 64;
    localparam int M_DATA_W  = 104;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_RUNTIME = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_ONE       = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_TWO       = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THREE     = 8'd3;

    localparam logic [LIMIT_W-1:0] LEVEL_ONE_RESET   = 16'd20;
    localparam logic [LIMIT_W-1:0] LEVEL_TWO_RESET   = 16'd100;
    localparam logic [LIMIT_W-1:0] LEVEL_THREE_RESET = 16'd150;

    // Demand levels.
    localparam logic [LEVEL_W-1:0] LEVEL_LOW       = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_NORMAL    = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_HIGH      = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_VERY_HIGH = 2'd3;

    localparam logic [PERIOD_W-1:0] PERIOD_LOW       = 30'd800000000;
    localparam logic [PERIOD_W-1:0] PERIOD_NORMAL    = 30'd500000000;
    localparam logic [PERIOD_W-1:0] PERIOD_HIGH      = 30'd300000000;
    localparam logic [PERIOD_W-1:0] PERIOD_VERY_HIGH = 30'd200000000;

    // floor(x / 5) = (x * RECIP_FIVE) >> RECIP_SHIFT for every 32-bit x.
    localparam logic [31:0] RECIP_FIVE  = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 34;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic             report;
        logic [ERR_W-1:0] err;
    } ewbs_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic push;
        logic pop;
    } ewbs_q_status_t;

    typedef struct packed {
        logic [BASE_W-1:0]  nominal_runtime;
        logic [LIMIT_W-1:0] level_one_limit;
        logic [LIMIT_W-1:0] level_two_limit;
        logic [LIMIT_W-1:0] level_three_limit;
    } ewbs_cfg_t;

    typedef struct packed {
        logic [OUT_SUM_W-1:0] error_sum;
        logic [LEVEL_W-1:0]   level;
        logic [PERIOD_W-1:0]  period_ns;
        logic [RUNTIME_W-1:0] runtime_ns;
    } ewbs_result_t;

    typedef struct packed {
        logic busy;
        logic load;
    } ewbs_back_status_t;

endpackage

// ===== sv/ewbs_front.sv =====
// Front stage: accepts input items, classifies restart or report and forms
// the absolute error. Depends on ewbs_pkg.
`timescale 1ns / 1ps

module ewbs_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_mode,
    input  logic [ewbs_pkg::ERR_W-1:0]    in_expected,
    input  logic [ewbs_pkg::ERR_W-1:0]    in_actual,
    output logic                          push,
    output ewbs_pkg::ewbs_entry_t         push_entry,
    input  logic                          queue_full
);

    logic                  hold_vld_reg;
    ewbs_pkg::ewbs_entry_t hold_entry_reg;
    ewbs_pkg::ewbs_entry_t entry_next;
    logic [ewbs_pkg::ERR_W:0] diff;

    // A 33-bit signed difference always has a magnitude that fits in 32 bits.
    always_comb begin
        diff              = {in_expected[ewbs_pkg::ERR_W-1], in_expected}
                          - {in_actual[ewbs_pkg::ERR_W-1], in_actual};
        entry_next.report = in_mode;
        entry_next.err    = diff[ewbs_pkg::ERR_W] ? ewbs_pkg::ERR_W'(-diff)
                                                  : diff[ewbs_pkg::ERR_W-1:0];
    end

    assign in_ready   = !hold_vld_reg || !queue_full;
    assign push       = hold_vld_reg && !queue_full;
    assign push_entry = hold_entry_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_vld_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            hold_vld_reg <= 1'b1;
        end else if (push) begin
            hold_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            hold_entry_reg <= entry_next;
        end
    end

endmodule

// ===== sv/ewbs_queue.sv =====
// Two-entry queue between the front and back stages.
// Depends on ewbs_pkg.
`timescale 1ns / 1ps

module ewbs_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  ewbs_pkg::ewbs_entry_t   push_entry,
    input  logic                    pop,
    output logic                    head_valid,
    output ewbs_pkg::ewbs_entry_t   head_entry,
    output ewbs_pkg::ewbs_q_status_t status
);

    localparam int PTR_W = $clog2(ewbs_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(ewbs_pkg::QUEUE_DEPTH + 1);

    ewbs_pkg::ewbs_entry_t slots_reg [ewbs_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == CNT_W'(ewbs_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign status.push  = do_push;
    assign status.pop   = do_pop;
    assign head_valid   = !status.empty;
    assign head_entry   = slots_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(ewbs_pkg::QUEUE_DEPTH - 1))
                            ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(ewbs_pkg::QUEUE_DEPTH - 1))
                            ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== sv/ewbs_back.sv =====
// Back stage: keeps the error window, sums it one slot a cycle, picks the
// demand level and scales the runtime. Depends on ewbs_pkg.
`timescale 1ns / 1ps

module ewbs_back #(
    parameter int WINDOW = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ewbs_pkg::ewbs_cfg_t         cfg,
    input  logic                        head_valid,
    input  ewbs_pkg::ewbs_entry_t       head_entry,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output ewbs_pkg::ewbs_result_t      out_result,
    output ewbs_pkg::ewbs_back_status_t status
);

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W = ewbs_pkg::ERR_W + $clog2(WINDOW);
    localparam int ACC_W = (SUM_W > ewbs_pkg::OUT_SUM_W) ? SUM_W : ewbs_pkg::OUT_SUM_W;
    localparam int PROD_W = 64;
    localparam int RECIP_SHIFT_L = ewbs_pkg::RECIP_SHIFT;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t                          state_reg;
    logic [WINDOW-1:0]               filled_reg;
    logic [IDX_W-1:0]                wr_slot_reg;
    logic [IDX_W-1:0]                rd_idx_reg;
    logic                            rd_vld_reg;
    logic                            rd_use_reg;
    logic [ewbs_pkg::ERR_W-1:0]      rd_data_reg;
    logic [ACC_W-1:0]                acc_reg;
    logic [PROD_W-1:0]               prod_reg;
    logic                            out_vld_reg;
    ewbs_pkg::ewbs_result_t          out_reg;
    logic [ewbs_pkg::ERR_W-1:0]      err_mem [WINDOW];

    logic                            mem_we;
    logic                            load;
    logic [IDX_W-1:0]                wr_slot_inc;
    logic [ewbs_pkg::BASE_W-3:0]     fifth;
    logic [ewbs_pkg::BASE_W-4:0]     tenth;
    logic [ewbs_pkg::RUNTIME_W-1:0]  base_ext;
    ewbs_pkg::ewbs_result_t          result_next;

    assign pop         = (state_reg == ST_IDLE) && head_valid;
    assign mem_we      = pop && head_entry.report;
    assign load        = (state_reg == ST_FINISH) && (!out_vld_reg || out_ready);
    assign wr_slot_inc = (wr_slot_reg == IDX_W'(WINDOW - 1)) ? '0 : wr_slot_reg + 1'b1;
    assign out_valid   = out_vld_reg;
    assign out_result  = out_reg;
    assign status.busy = (state_reg != ST_IDLE);
    assign status.load = load;

    // The runtime steps of 110 and 120 percent add a tenth or a fifth of base.
    always_comb begin
        fifth    = prod_reg[PROD_W-1:RECIP_SHIFT_L];
        tenth    = fifth[ewbs_pkg::BASE_W-3:1];
        base_ext = {1'b0, cfg.nominal_runtime};
        result_next.error_sum = (acc_reg > ACC_W'({ewbs_pkg::OUT_SUM_W{1'b1}}))
                              ? {ewbs_pkg::OUT_SUM_W{1'b1}}
                              : acc_reg[ewbs_pkg::OUT_SUM_W-1:0];
        if (acc_reg < ACC_W'(cfg.level_one_limit)) begin
            result_next.level      = ewbs_pkg::LEVEL_LOW;
            result_next.period_ns  = ewbs_pkg::PERIOD_LOW;
            result_next.runtime_ns = base_ext >> 1;
        end else if (acc_reg < ACC_W'(cfg.level_two_limit)) begin
            result_next.level      = ewbs_pkg::LEVEL_NORMAL;
            result_next.period_ns  = ewbs_pkg::PERIOD_NORMAL;
            result_next.runtime_ns = base_ext;
        end else if (acc_reg < ACC_W'(cfg.level_three_limit)) begin
            result_next.level      = ewbs_pkg::LEVEL_HIGH;
            result_next.period_ns  = ewbs_pkg::PERIOD_HIGH;
            result_next.runtime_ns = base_ext + ewbs_pkg::RUNTIME_W'(tenth);
        end else begin
            result_next.level      = ewbs_pkg::LEVEL_VERY_HIGH;
            result_next.period_ns  = ewbs_pkg::PERIOD_VERY_HIGH;
            result_next.runtime_ns = base_ext + ewbs_pkg::RUNTIME_W'(fifth);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            err_mem[wr_slot_reg] <= head_entry.err;
        end
        rd_data_reg <= err_mem[rd_idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            filled_reg  <= '0;
            wr_slot_reg <= '0;
            rd_idx_reg  <= '0;
            rd_vld_reg  <= 1'b0;
            rd_use_reg  <= 1'b0;
            acc_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            if (rd_vld_reg && rd_use_reg) begin
                acc_reg <= acc_reg + ACC_W'(rd_data_reg);
            end
            if (load) begin
                out_vld_reg <= 1'b1;
                out_reg     <= result_next;
            end else if (out_ready) begin
                out_vld_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    rd_vld_reg <= 1'b0;
                    if (pop) begin
                        if (head_entry.report) begin
                            filled_reg[wr_slot_reg] <= 1'b1;
                            wr_slot_reg             <= wr_slot_inc;
                            rd_idx_reg              <= '0;
                            acc_reg                 <= '0;
                            state_reg               <= ST_SUM;
                        end else begin
                            filled_reg  <= '0;
                            wr_slot_reg <= '0;
                        end
                    end
                end
                ST_SUM: begin
                    // The memory read issued here lands in rd_data_reg next cycle.
                    rd_vld_reg <= 1'b1;
                    rd_use_reg <= filled_reg[rd_idx_reg];
                    if (rd_idx_reg == IDX_W'(WINDOW - 1)) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    rd_vld_reg <= 1'b0;
                    prod_reg   <= PROD_W'(cfg.nominal_runtime) * PROD_W'(ewbs_pkg::RECIP_FIVE);
                    state_reg  <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/error_window_budget_selector_core.sv =====
// Error window budget selector: an adaptive scheduling controller.
//
// Input channel (s_): tuser carries the mode (0 restart, 1 report), tdata the
// expected and actual values. A restart clears the error history and gives no
// item on the output; a report stores |expected - actual| in a ring of WINDOW
// slots and yields one output item with the window sum, the demand level,
// its fixed period and the scaled runtime.
// Configuration channel (cfg_): cfg_index picks the register, cfg_data holds
// the value; cfg_ready is always high. Write only while the block is idle.
//
// Timing: an item passes the front register into the queue; the back stage then
// writes a report into the error memory, reads one slot of the window per cycle
// from that memory and sums it, then drains and finishes, while a restart is
// handled in the idle state alone.
// A two-entry queue parts front and back, so new items are accepted while the
// back stage works or while a result waits in the output register.
// When the receiver stalls the output item holds; once the queue and front
// register are full, s_tready drops. Reset empties the history and loads the
// register defaults. Depends on ewbs_pkg, ewbs_front, ewbs_queue, ewbs_back.
`timescale 1ns / 1ps

module error_window_budget_selector_core #(
    parameter int WINDOW = 10
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [31:0] expected_value, [63:32] actual_value
    input  logic [ewbs_pkg::S_DATA_W-1:0]      s_tdata,
    // [0] mode
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [35:0] error_sum, [37:36] level, [67:38] period_ns, [100:68] runtime_ns
    output logic [ewbs_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ewbs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ewbs_pkg::CFG_DAT_W-1:0]     cfg_data
);

    ewbs_pkg::ewbs_cfg_t          cfg_reg;
    logic                         push;
    ewbs_pkg::ewbs_entry_t        push_entry;
    logic                         pop;
    logic                         head_valid;
    ewbs_pkg::ewbs_entry_t        head_entry;
    ewbs_pkg::ewbs_q_status_t     q_status;
    ewbs_pkg::ewbs_back_status_t  back_status;
    ewbs_pkg::ewbs_result_t       result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.nominal_runtime   <= '0;
            cfg_reg.level_one_limit   <= ewbs_pkg::LEVEL_ONE_RESET;
            cfg_reg.level_two_limit   <= ewbs_pkg::LEVEL_TWO_RESET;
            cfg_reg.level_three_limit <= ewbs_pkg::LEVEL_THREE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ewbs_pkg::REG_NOMINAL_RUNTIME: cfg_reg.nominal_runtime <= cfg_data;
                ewbs_pkg::REG_LEVEL_ONE:
                    cfg_reg.level_one_limit <= cfg_data[ewbs_pkg::LIMIT_W-1:0];
                ewbs_pkg::REG_LEVEL_TWO:
                    cfg_reg.level_two_limit <= cfg_data[ewbs_pkg::LIMIT_W-1:0];
                ewbs_pkg::REG_LEVEL_THREE:
                    cfg_reg.level_three_limit <= cfg_data[ewbs_pkg::LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ewbs_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_mode     (s_tuser),
        .in_expected (s_tdata[31:0]),
        .in_actual   (s_tdata[63:32]),
        .push        (push),
        .push_entry  (push_entry),
        .queue_full  (q_status.full)
    );

    ewbs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .status     (q_status)
    );

    ewbs_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result),
        .status     (back_status)
    );

    assign m_tdata = {3'b000, result.runtime_ns, result.period_ns,
                      result.level, result.error_sum};

    // The back stage takes a queue entry only when it has nothing in hand.
    a_pop_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.pop |-> !back_status.busy)
        else $error("back stage popped the queue while busy");

    // The front never pushes into a full queue.
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_status.full)
        else $error("push into a full queue");

    // A result appears only after the back stage finished a report.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(back_status.load))
        else $error("output item appeared without a finished report");

    // Loading a result while the old one still waits would lose an item.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !back_status.load)
        else $error("output register overwritten while stalled");

endmodule
